### rtl/aoc_pkg.sv
// Shared types and constants of the audio output clip and format stage.
package aoc_pkg;

    localparam int SAMPLE_W = 28;
    localparam int OUT_W    = 24;
    localparam int WORD_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int MODE_W   = 2;
    localparam int PEAK_W   = 27;
    localparam int ACC_W    = SAMPLE_W + GAIN_W;
    localparam int AQ_W     = 32;
    localparam int MAG_W    = 23;
    localparam int QUO_W    = 19;
    localparam int REM_W    = 37;
    localparam int DSH_W    = AQ_W + QUO_W - 1;
    localparam int STEP_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [AQ_W-1:0]   CLIP_TH   = 32'd7957433;
    localparam logic [AQ_W-1:0]   KNEE_Q    = 32'd7704013;
    localparam logic [AQ_W-1:0]   EPS_Q     = 32'd8389;
    localparam logic [MAG_W-1:0]  CLIP_GAIN = 23'd8220835;
    // Product of the clip gain and the epsilon term.
    localparam logic [REM_W-1:0]  CLIP_K    = 37'd68964584815;
    localparam logic [PEAK_W-1:0] LED_TH    = 27'd7549747;
    localparam logic [PEAK_W-1:0] PEAK_MAX  = 27'h7FFFFFF;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;

    localparam logic [MODE_W-1:0] MODE_DIRECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BALANCED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MONITOR  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic div;
        logic fin;
    } t_lane_ctl;

endpackage

### rtl/audio_output_clip_format_core.sv
// Top level of the audio output stage: volume, soft clip, output mode, packing, peak LED.
// Each clipper lane runs a bit-serial volume multiply over the 16 gain bits and, after a
// prep step, a restoring division for 19 quotient bits; a finish step and a done state that
// waits for a free output register follow. The input stalls until the sequencer is idle.
// The three lanes (left, right, monitor) run in lockstep from one sequencer.
// Synchronous active-low reset clears the sequencer, the output valid flag, the peak
// meter and the registers (volume 4096, direct mode); no clearing pass is needed.
module audio_output_clip_format_core
    import aoc_pkg::*;
#(
    parameter int PEAK_WINDOW = 512
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [GAIN_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [SAMPLE_W-1:0] i_monitor_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [WORD_W-1:0]          o_left_word,
    output logic [WORD_W-1:0]          o_right_word,
    output logic                       o_overload_led
);

    localparam int CNT_W = (PEAK_WINDOW > 2) ? $clog2(PEAK_WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PEAK_WINDOW - 1);

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain;
    logic [MODE_W-1:0] r_mode;

    // Sequencer.
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_lane_ctl         lane_ctl;
    logic              load_out;
    logic              in_accept;

    // Peak meter.
    logic [PEAK_W-1:0] r_peak;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_led;
    logic [SAMPLE_W-1:0] left_mag;
    logic [PEAK_W-1:0] left_peak;
    logic [PEAK_W-1:0] peak_max;

    // Result registers.
    logic              r_out_valid;
    logic [WORD_W-1:0] r_left_word;
    logic [WORD_W-1:0] r_right_word;
    logic              r_out_led;

    logic signed [OUT_W-1:0] clip_left;
    logic signed [OUT_W-1:0] clip_right;
    logic signed [OUT_W-1:0] clip_mon;
    logic signed [OUT_W-1:0] sel_left;
    logic signed [OUT_W-1:0] sel_right;

    // The clipper lanes share the sequencer's control word.
    aoc_clip_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_left_sample),
        .i_gain   (r_gain),
        .o_sample (clip_left)
    );

    aoc_clip_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_right_sample),
        .i_gain   (r_gain),
        .o_sample (clip_right)
    );

    aoc_clip_lane u_lane_mon (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (i_monitor_sample),
        .i_gain   (r_gain),
        .o_sample (clip_mon)
    );

    assign in_accept  = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and lane controls. A new request is taken in idle even while the
    // previous result still waits in the output register.
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        lane_ctl = '0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    lane_ctl.load = 1'b1;
                    n_step        = '0;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                lane_ctl.mul = 1'b1;
                if (r_step == STEP_W'(GAIN_W - 1)) begin
                    n_step  = '0;
                    n_state = S_PREP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PREP: begin
                lane_ctl.prep = 1'b1;
                n_step        = '0;
                n_state       = S_DIV;
            end
            S_DIV: begin
                lane_ctl.div = 1'b1;
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_step  = '0;
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                lane_ctl.fin = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free or being emptied now.
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_mode <= MODE_DIRECT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_VOLUME) begin
                r_gain <= i_cfg_data;
            end else if (i_cfg_index == CFG_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end
        end
    end

    // The peak meter looks at the raw left sample, before volume. The most
    // negative sample saturates to the largest 27-bit magnitude.
    assign left_mag  = i_left_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_left_sample)
                                                 : SAMPLE_W'(i_left_sample);
    assign left_peak = left_mag[SAMPLE_W-1] ? PEAK_MAX : left_mag[PEAK_W-1:0];
    assign peak_max  = (left_peak > r_peak) ? left_peak : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_cnt  <= '0;
            r_led  <= 1'b0;
        end else if (in_accept) begin
            if (r_cnt == CNT_LAST) begin
                // End of window: latch the LED and start a fresh peak.
                r_cnt  <= '0;
                r_led  <= peak_max > LED_TH;
                r_peak <= '0;
            end else begin
                r_cnt  <= r_cnt + 1'b1;
                r_peak <= peak_max;
            end
        end
    end

    // Output mode selection. Line mode halves with an arithmetic shift, which
    // rounds toward minus infinity.
    always_comb begin
        sel_left  = clip_left;
        sel_right = clip_right;
        case (r_mode)
            MODE_DIRECT: begin
                sel_left  = clip_left;
                sel_right = clip_right;
            end
            MODE_LINE: begin
                sel_left  = clip_left >>> 1;
                sel_right = clip_right >>> 1;
            end
            MODE_BALANCED: begin
                sel_right = -clip_left;
            end
            MODE_MONITOR: begin
                sel_left = clip_mon;
            end
            default: begin
                sel_left  = clip_left;
                sel_right = clip_right;
            end
        endcase
    end

    // Codec packing: the sample shifted left by 8 and rotated by 16 bits.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_left_word  <= {sel_left[7:0], 8'h00, sel_left[OUT_W-1:8]};
            r_right_word <= {sel_right[7:0], 8'h00, sel_right[OUT_W-1:8]};
            r_out_led    <= r_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_word    = r_left_word;
    assign o_right_word   = r_right_word;
    assign o_overload_led = r_out_led;

endmodule

### rtl/aoc_clip_lane.sv
// One clipper lane: bit-serial volume multiply and bit-serial rational division.
module aoc_clip_lane
    import aoc_pkg::*;
(
    input  logic                       i_clk,
    input  t_lane_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [OUT_W-1:0]    o_sample
);

    logic                r_neg;
    logic [SAMPLE_W-1:0] r_mag;
    logic [GAIN_W-1:0]   r_gain;
    logic [ACC_W-1:0]    r_acc;
    logic                r_clip;
    logic [MAG_W-1:0]    r_lin;
    logic [REM_W-1:0]    r_rem;
    logic [DSH_W-1:0]    r_dsh;
    logic [QUO_W-1:0]    r_quo;
    logic [OUT_W-1:0]    r_res;

    logic [AQ_W-1:0]     a_q;
    logic [AQ_W-1:0]     den;
    logic                fits;
    logic [QUO_W-1:0]    quo_ceil;
    logic [MAG_W-1:0]    mag_out;

    assign a_q      = r_acc[ACC_W-1:12];
    assign den      = a_q - KNEE_Q + EPS_Q;
    assign fits     = {{(DSH_W-REM_W){1'b0}}, r_rem} >= r_dsh;
    // Clipped magnitude is CLIP_GAIN - ceil(CLIP_K / (b + eps)).
    assign quo_ceil = r_quo + QUO_W'(r_rem != '0);
    assign mag_out  = r_clip ? (CLIP_GAIN - MAG_W'(quo_ceil)) : r_lin;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg  <= i_sample[SAMPLE_W-1];
            r_mag  <= i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : SAMPLE_W'(i_sample);
            r_gain <= i_gain;
            r_acc  <= '0;
        end
        if (i_ctl.mul) begin
            r_acc  <= {r_acc[ACC_W-2:0], 1'b0}
                      + (r_gain[GAIN_W-1] ? ACC_W'(r_mag) : '0);
            r_gain <= {r_gain[GAIN_W-2:0], 1'b0};
        end
        if (i_ctl.prep) begin
            r_clip <= a_q > CLIP_TH;
            // Up to the clip threshold the gain of 8388607/2^23 reduces to a - 1.
            r_lin  <= (a_q == '0) ? '0 : MAG_W'(a_q - 1'b1);
            r_rem  <= CLIP_K;
            r_dsh  <= {den, {(QUO_W-1){1'b0}}};
            r_quo  <= '0;
        end
        if (i_ctl.div) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[REM_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_dsh <= {1'b0, r_dsh[DSH_W-1:1]};
        end
        if (i_ctl.fin) begin
            r_res <= r_neg ? OUT_W'(-{1'b0, mag_out}) : OUT_W'({1'b0, mag_out});
        end
    end

    assign o_sample = r_res;

endmodule

### tb/codec_word_checker.sv
// Checker that predicts the codec words and overload flag of each request and compares results.
module codec_word_checker
    import aoc_pkg::*;
#(
    parameter int PEAK_WINDOW = 512
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [GAIN_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [SAMPLE_W-1:0] i_monitor_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [WORD_W-1:0]          i_left_word,
    input  logic [WORD_W-1:0]          i_right_word,
    input  logic                       i_overload_led,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Clipper and meter constants in Q.23.
    localparam longint CLIP_START     = 7957433;
    localparam longint KNEE_POINT     = 7704013;
    localparam longint SOFT_EPS       = 8389;
    localparam longint SOFT_GAIN      = 8220835;
    localparam longint UNITY_SCALE    = 8388607;
    localparam longint OVERLOAD_LEVEL = 7549747;
    localparam longint PEAK_CEIL      = 134217727;
    localparam int     REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        logic              overload;
    } t_codec_result;

    logic [GAIN_W-1:0] volume = GAIN_RESET;
    logic [MODE_W-1:0] mode = MODE_DIRECT;
    longint            peak_hold = 0;
    int                window_fill = 0;
    logic              overload = 1'b0;
    t_codec_result     due_words[$];
    int                failures = 0;
    int                reported = 0;

    // Volume, then the rational soft clip on the magnitude, then the sign back.
    function automatic logic signed [OUT_W-1:0] soft_clip(input logic signed [SAMPLE_W-1:0] x);
        longint wide;
        longint level;
        longint bend;
        longint shaped;
        logic signed [OUT_W-1:0] clipped;
        wide = longint'(x);
        if (wide < 0) begin
            wide = -wide;
        end
        level = (wide * longint'(volume)) >> 12;
        if (level > CLIP_START) begin
            bend = level - KNEE_POINT;
            shaped = (SOFT_GAIN * bend) / (bend + SOFT_EPS);
        end else begin
            shaped = (level * UNITY_SCALE) >> 23;
        end
        clipped = shaped[OUT_W-1:0];
        return (x < 0) ? -clipped : clipped;
    endfunction

    // Sample shifted up by 8 into a 32-bit word, then the halves swapped.
    function automatic logic [WORD_W-1:0] codec_word(input logic signed [OUT_W-1:0] s);
        logic [WORD_W-1:0] w;
        w = {s, 8'h00};
        return {w[15:0], w[31:16]};
    endfunction

    // Advances the peak meter and works out the result of one request.
    function automatic t_codec_result codec_frame(input logic signed [SAMPLE_W-1:0] l,
                                                  input logic signed [SAMPLE_W-1:0] r,
                                                  input logic signed [SAMPLE_W-1:0] m);
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        longint level;
        t_codec_result res;
        // The meter sees the raw left sample; the most negative one saturates.
        level = longint'(l);
        if (level < 0) begin
            level = -level;
        end
        if (level > PEAK_CEIL) begin
            level = PEAK_CEIL;
        end
        if (level > peak_hold) begin
            peak_hold = level;
        end
        window_fill = (window_fill + 1) % PEAK_WINDOW;
        if (window_fill == 0) begin
            overload = (peak_hold > OVERLOAD_LEVEL);
            peak_hold = 0;
        end
        left_out = soft_clip(l);
        right_out = soft_clip(r);
        case (mode)
            MODE_LINE: begin
                // Arithmetic shift rounds toward minus infinity.
                left_out = left_out >>> 1;
                right_out = right_out >>> 1;
            end
            MODE_BALANCED: begin
                right_out = -left_out;
            end
            MODE_MONITOR: begin
                left_out = soft_clip(m);
            end
            default: begin
            end
        endcase
        res.left_word = codec_word(left_out);
        res.right_word = codec_word(right_out);
        res.overload = overload;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_codec_result seen;
        t_codec_result due;
        if (!i_rst_n) begin
            volume = GAIN_RESET;
            mode = MODE_DIRECT;
            peak_hold = 0;
            window_fill = 0;
            overload = 1'b0;
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = '{left_word: i_left_word, right_word: i_right_word,
                         overload: i_overload_led};
                if (due_words.size() == 0) begin
                    failures++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("unexpected result: left %h right %h led %b",
                                 seen.left_word, seen.right_word, seen.overload);
                    end
                end else begin
                    due = due_words.pop_front();
                    if (seen != due) begin
                        failures++;
                        if (reported < REPORT_LIMIT) begin
                            reported++;
                            $display({"mismatch: expected left %h right %h led %b, ",
                                      "got left %h right %h led %b"},
                                     due.left_word, due.right_word, due.overload,
                                     seen.left_word, seen.right_word, seen.overload);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_words.push_back(codec_frame(i_left_sample, i_right_sample,
                                                i_monitor_sample));
            end
            // Writes only come while idle, so their order against requests does not matter.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VOLUME: volume = i_cfg_data;
                    CFG_MODE:   mode = i_cfg_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= failures;
        o_pending <= due_words.size();
    end

endmodule

### tb/tb_audio_output_clip_format_core.sv
// Testbench top of the audio output stage: request stimulus, register writes and the verdict.
module tb_audio_output_clip_format_core;
    timeunit 1ns;
    timeprecision 1ps;
    import aoc_pkg::*;

    localparam int PEAK_WINDOW  = 512;
    // Generous bound: every request waiting out the longest gaps and stalls, many times over.
    localparam int CYCLE_LIMIT  = 600000;
    // Longer than the path from an accepted request to its result, so this covers any late or stray result.
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 500;
    localparam int HOLD_BURST   = 20;
    // The second peak window sees only quiet left samples, so the LED has to drop.
    localparam int QUIET_FROM   = PEAK_WINDOW;
    localparam int QUIET_TO     = 2 * PEAK_WINDOW;
    // From here on neither side idles.
    localparam int CALM_FROM    = 1170;

    localparam int CLIP_EDGE = 7957433;
    localparam int LED_EDGE  = 7549747;
    localparam int MAG_TOP   = 134217727;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 28'sh7FFFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 28'sh8000000;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_VOLUME;
    logic [GAIN_W-1:0]          i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic signed [SAMPLE_W-1:0] i_monitor_sample = '0;
    logic                       i_out_stall = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [WORD_W-1:0]          o_left_word;
    logic [WORD_W-1:0]          o_right_word;
    logic                       o_overload_led;

    int                fail_count;
    int                pending;
    int                requests_sent = 0;
    int                hold_requests = 0;
    int                cycle_count = 0;
    bit                calm = 1'b0;
    logic [GAIN_W-1:0] current_gain = GAIN_RESET;

    audio_output_clip_format_core #(
        .PEAK_WINDOW (PEAK_WINDOW)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_monitor_sample (i_monitor_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_word      (o_left_word),
        .o_right_word     (o_right_word),
        .o_overload_led   (o_overload_led)
    );

    codec_word_checker #(
        .PEAK_WINDOW (PEAK_WINDOW)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_monitor_sample (i_monitor_sample),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_left_word      (o_left_word),
        .i_right_word     (o_right_word),
        .i_overload_led   (o_overload_led),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_audio_output_clip_format_core: done, errors");
            $finish;
        end
    end

    // The result side stalls in random bursts, takes long quiet stretches now and then,
    // and holds off for a long counted stretch whenever the stimulus asks for one.
    initial begin : result_stall_gen
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != served) begin
                served = hold_requests;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && i_rst_n && $urandom_range(0, 99) < 8) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 299) == 0) begin
                repeat ($urandom_range(100, 400)) @(posedge i_clk);
            end
        end
    end

    // Offers one request and holds it until the block takes it. Valid is left high, so a
    // following request goes out back to back.
    task automatic send_request(input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r,
                                input logic signed [SAMPLE_W-1:0] m);
        i_in_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        i_monitor_sample <= m;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        if (requests_sent == CALM_FROM) begin
            calm <= 1'b1;
        end
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has been taken. The checker's
    // count is registered, so the task waits on a clock edge before it first looks at it.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One write, then a pause with the enable low so that writes never merge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // The mode write carries random upper bits, which the block must mask off.
    task automatic configure(input logic [GAIN_W-1:0] gain, input logic [MODE_W-1:0] mode_sel);
        logic [GAIN_W-1:0] mode_word;
        mode_word = GAIN_W'($urandom);
        mode_word[MODE_W-1:0] = mode_sel;
        wait_drained();
        write_reg(CFG_VOLUME, gain);
        write_reg(CFG_MODE, mode_word);
        current_gain = gain;
    endtask

    // Picks one sample: raw random words, the extremes, the clip knee and the LED level in
    // Q.23, a magnitude that lands on the knee after the current volume, and audio-range
    // values. A quiet pick never goes above the LED level.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit quiet);
        longint mag;
        bit negative;
        negative = 1'($urandom_range(0, 1));
        if (quiet) begin
            mag = ($urandom_range(0, 9) == 0) ? LED_EDGE : $urandom_range(0, LED_EDGE);
            return SAMPLE_W'(negative ? -mag : mag);
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                return SAMPLE_W'($urandom);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return SAMPLE_W'(negative ? -1 : 1);
                endcase
            end
            3: mag = CLIP_EDGE - 64 + $urandom_range(0, 128);
            4: mag = LED_EDGE - 64 + $urandom_range(0, 128);
            5: begin
                if (current_gain == 0) begin
                    mag = $urandom_range(0, MAG_TOP);
                end else begin
                    mag = ((longint'(CLIP_EDGE) << 12) / current_gain) - 8 + $urandom_range(0, 16);
                end
                if (mag > MAG_TOP) begin
                    mag = $urandom_range(0, MAG_TOP);
                end
            end
            6: mag = $urandom_range(0, MAG_TOP);
            default: mag = $urandom_range(0, 1 << 23);
        endcase
        return SAMPLE_W'(negative ? -mag : mag);
    endfunction

    // One phase of random requests under one setting. Some phases run without gaps; the
    // held phase sends a back-to-back burst while the result side holds off, so the block
    // fills up and stalls its input.
    task automatic random_phase(input logic [GAIN_W-1:0] gain, input logic [MODE_W-1:0] mode_sel,
                                input int count, input bit with_hold);
        int gap_pct;
        bit quiet;
        configure(gain, mode_sel);
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
        if (with_hold) begin
            hold_requests <= hold_requests + 1;
        end
        for (int k = 0; k < count; k++) begin
            if (requests_sent < CALM_FROM && !(with_hold && k < HOLD_BURST)
                    && $urandom_range(0, 99) < gap_pct) begin
                idle_sender($urandom_range(1, 18));
            end
            quiet = (requests_sent >= QUIET_FROM && requests_sent < QUIET_TO);
            send_request(pick_sample(quiet), pick_sample(1'b0), pick_sample(1'b0));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first: unity volume and direct mode. These cover the extremes, both
        // sides of the clip knee and of the LED level, and small odd values.
        send_request('0, '0, '0);
        send_request(SAMPLE_MAX, SAMPLE_MIN, 1);
        send_request(SAMPLE_MIN, SAMPLE_MAX, -1);
        send_request(SAMPLE_W'(CLIP_EDGE), SAMPLE_W'(-CLIP_EDGE), SAMPLE_W'(CLIP_EDGE + 1));
        send_request(SAMPLE_W'(CLIP_EDGE + 1), SAMPLE_W'(-(CLIP_EDGE + 1)),
                     SAMPLE_W'(-CLIP_EDGE));
        send_request(8388607, -8388608, 8388608);
        send_request(SAMPLE_W'(LED_EDGE), SAMPLE_W'(LED_EDGE + 1), -3);
        send_request(SAMPLE_W'(-(LED_EDGE + 1)), -4, 3);
        send_request(1, -1, 0);
        send_request(-3, 5, -5);

        // Largest volume: the most negative input drives the clipper with its full magnitude.
        configure(16'hFFFF, MODE_DIRECT);
        send_request(SAMPLE_MIN, SAMPLE_MAX, '0);
        send_request(2047, -2048, 7);

        // Line mode halves by flooring, so odd negative values round away from zero.
        configure(GAIN_RESET, MODE_LINE);
        send_request(-3, 3, '0);
        send_request(SAMPLE_MIN, -1, '0);
        send_request(-8388607, 8388607, '0);

        configure(GAIN_RESET, MODE_BALANCED);
        send_request(SAMPLE_W'(-(CLIP_EDGE + 1)), 12345, '0);
        send_request(SAMPLE_MAX, '0, '0);

        // Writes to indexes past the list must leave volume and mode as they are.
        configure(16'hFFFF, MODE_MONITOR);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_request(5, -7, SAMPLE_MIN);
        send_request('0, 1, SAMPLE_MAX);
        send_request(3, 3, SAMPLE_W'(-CLIP_EDGE));

        configure(16'h0000, MODE_MONITOR);
        send_request(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);

        // Random part. Each phase starts with the sender paused until all results are in.
        random_phase(GAIN_RESET, MODE_DIRECT, 150, 1'b0);
        random_phase(GAIN_W'($urandom_range(0, 65535)), MODE_LINE, 140, 1'b0);
        random_phase(16'hFFFF, MODE_BALANCED, 130, 1'b0);
        random_phase(16'd1, MODE_MONITOR, 120, 1'b0);
        random_phase(16'd0, MODE_DIRECT, 80, 1'b0);
        random_phase(GAIN_W'($urandom_range(2048, 12000)), MODE_W'($urandom_range(0, 3)),
                     160, 1'b0);
        random_phase(16'd8192, MODE_MONITOR, 160, 1'b1);
        random_phase(GAIN_RESET, MODE_LINE, 150, 1'b0);
        random_phase(GAIN_W'($urandom_range(0, 65535)), MODE_BALANCED, 160, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_audio_output_clip_format_core: done, clean");
        end else begin
            $display("tb_audio_output_clip_format_core: done, errors");
        end
        $finish;
    end

endmodule
